// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("check failed");

// cons must hold at every clock edge at which ante holds, outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

`endif

// File: rtl/rhc_pkg.sv
package rhc_pkg;

   localparam int CHANNEL_BITS_DEF = 8;

   localparam int HUE_W         = 13;
   localparam int HUE_SIXTH     = 960;
   localparam int HUE_FULL      = 5760;
   localparam int HUE_GREEN_OFS = 1920;
   localparam int HUE_BLUE_OFS  = 3840;
   localparam int HUE_MAG_W     = $clog2(HUE_SIXTH + 1);

endpackage

// File: rtl/rhc_div.sv
module rhc_div #(
   parameter int NUM_W = 17,
   parameter int DEN_W = 10,
   parameter int QUO_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo
);

   logic [NUM_W-1:0] rem_st [0:QUO_W];
   logic [DEN_W-1:0] den_st [0:QUO_W];
   logic [QUO_W-1:0] quo_st [0:QUO_W];
   logic             vld_st [0:QUO_W];

   logic [NUM_W-1:0] rem_in [0:QUO_W-1];
   logic [QUO_W-1:0] quo_in [0:QUO_W-1];

   logic [NUM_W-1:0] rem_ff [0:QUO_W-1];
   logic [DEN_W-1:0] den_ff [0:QUO_W-1];
   logic [QUO_W-1:0] quo_ff [0:QUO_W-1];
   logic             vld_ff [0:QUO_W-1];

   assign rem_st[0] = in_num;
   assign den_st[0] = in_den;
   assign quo_st[0] = '0;
   assign vld_st[0] = in_valid;

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      localparam int BIT = QUO_W - 1 - k;
      logic             take;
      logic [NUM_W-1:0] hi;

      assign hi   = rem_st[k] >> BIT;
      assign take = (hi >= NUM_W'(den_st[k]));

      always_comb begin
         rem_in[k] = rem_st[k];
         if (take) begin
            rem_in[k] = rem_st[k] - (NUM_W'(den_st[k]) << BIT);
         end
         quo_in[k] = {quo_st[k][QUO_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_st[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in[k];
         den_ff[k] <= den_st[k];
         quo_ff[k] <= quo_in[k];
      end

      assign rem_st[k+1] = rem_ff[k];
      assign den_st[k+1] = den_ff[k];
      assign quo_st[k+1] = quo_ff[k];
      assign vld_st[k+1] = vld_ff[k];
   end

   assign out_valid = vld_st[QUO_W];
   assign out_quo   = quo_st[QUO_W];

endmodule

// File: rtl/rgb_to_hsl_convert_unit.sv
// RGB to HSL pixel converter, fully pipelined.
// Request channel: drive req_red, req_green, req_blue and raise start; the
// request is taken at every rising edge with start high and busy low. busy
// stays low, so one pixel can be taken in every clock cycle.
// Result channel: rsp_valid is high for exactly one cycle with rsp_hue
// (sixteenths of a degree, 0..5759), rsp_saturation and rsp_lightness.
// Results leave in request order. The receiver cannot stall the block.
// Stages: an input register, a max/min stage, a numerator stage, the two
// restoring dividers (saturation and hue) working side by side, each
// resolving one quotient bit per pipeline stage for QUO_W =
// max(CHANNEL_BITS, 10) quotient bits, and the output register.
// Throughput: one pixel per cycle.
// Reset (synchronous, active high) drops every pixel in flight; no result
// is produced for a request taken before reset.
module rgb_to_hsl_convert_unit #(
   parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [CHANNEL_BITS-1:0]     req_red,
   input  logic [CHANNEL_BITS-1:0]     req_green,
   input  logic [CHANNEL_BITS-1:0]     req_blue,
   output logic                        rsp_valid,
   output logic [rhc_pkg::HUE_W-1:0]   rsp_hue,
   output logic [CHANNEL_BITS-1:0]     rsp_saturation,
   output logic [CHANNEL_BITS-1:0]     rsp_lightness
);

   import rhc_pkg::*;

`include "assert_macros.svh"

   localparam int CB        = CHANNEL_BITS;
   localparam int CH_MAX    = (1 << CB) - 1;
   localparam int QUO_W     = (CB > HUE_MAG_W) ? CB : HUE_MAG_W;
   localparam int SAT_NUM_W = 2 * CB + 1;
   localparam int SAT_DEN_W = CB + 2;
   localparam int HUE_NUM_W = CB + $clog2(2 * HUE_SIXTH + 1);
   localparam int HUE_DEN_W = CB + 1;

   typedef struct packed {
      logic             gray;
      logic             neg;
      logic [HUE_W-1:0] ofs;
      logic [CB-1:0]    light;
   } side_type;

   // input register
   logic          a_vld_ff;
   logic [CB-1:0] a_red_ff, a_green_ff, a_blue_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      a_red_ff   <= req_red;
      a_green_ff <= req_green;
      a_blue_ff  <= req_blue;
   end

   // max, min, channel difference
   logic             red_top, green_top;
   logic [CB-1:0]    mx, mn, pos, neg_ch;
   logic [CB-1:0]    b_d_in, b_diff_in;
   logic [CB:0]      b_s_in;
   logic             b_neg_in;
   logic [HUE_W-1:0] b_ofs_in;

   logic             b_vld_ff;
   logic [CB-1:0]    b_d_ff, b_diff_ff;
   logic [CB:0]      b_s_ff;
   logic             b_neg_ff;
   logic [HUE_W-1:0] b_ofs_ff;

   always_comb begin
      red_top   = (a_red_ff >= a_green_ff) && (a_red_ff >= a_blue_ff);
      green_top = !red_top && (a_green_ff >= a_blue_ff);
      mn = a_red_ff;
      if (a_green_ff < mn) begin
         mn = a_green_ff;
      end
      if (a_blue_ff < mn) begin
         mn = a_blue_ff;
      end
      if (red_top) begin
         mx       = a_red_ff;
         pos      = a_green_ff;
         neg_ch   = a_blue_ff;
         b_ofs_in = '0;
      end else if (green_top) begin
         mx       = a_green_ff;
         pos      = a_blue_ff;
         neg_ch   = a_red_ff;
         b_ofs_in = HUE_W'(HUE_GREEN_OFS);
      end else begin
         mx       = a_blue_ff;
         pos      = a_red_ff;
         neg_ch   = a_green_ff;
         b_ofs_in = HUE_W'(HUE_BLUE_OFS);
      end
      b_d_in   = mx - mn;
      b_s_in   = {1'b0, mx} + {1'b0, mn};
      b_neg_in = (pos < neg_ch);
      b_diff_in = b_neg_in ? (neg_ch - pos) : (pos - neg_ch);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_d_ff    <= b_d_in;
      b_diff_ff <= b_diff_in;
      b_s_ff    <= b_s_in;
      b_neg_ff  <= b_neg_in;
      b_ofs_ff  <= b_ofs_in;
   end

   // numerators and denominators, rounding folded in
   logic [CB:0]          s_p1;
   logic [CB:0]          den_sat;
   logic [SAT_NUM_W-1:0] c_sat_num_in;
   logic [HUE_NUM_W-1:0] c_hue_num_in;
   side_type             c_side_in;

   logic                 c_vld_ff;
   logic [SAT_NUM_W-1:0] c_sat_num_ff;
   logic [SAT_DEN_W-1:0] c_sat_den_ff;
   logic [HUE_NUM_W-1:0] c_hue_num_ff;
   logic [HUE_DEN_W-1:0] c_hue_den_ff;
   side_type             c_side_ff;

   always_comb begin
      s_p1 = b_s_ff + (CB+1)'(1);
      if (b_s_ff < (CB+1)'(CH_MAX)) begin
         den_sat = b_s_ff;
      end else begin
         den_sat = (CB+1)'(2 * CH_MAX) - b_s_ff;
      end
      c_sat_num_in = SAT_NUM_W'(b_d_ff) * SAT_NUM_W'(2 * CH_MAX) + SAT_NUM_W'(den_sat);
      c_hue_num_in = HUE_NUM_W'(b_diff_ff) * HUE_NUM_W'(2 * HUE_SIXTH) + HUE_NUM_W'(b_d_ff);
      c_side_in.gray  = (b_d_ff == '0);
      c_side_in.neg   = b_neg_ff;
      c_side_in.ofs   = b_ofs_ff;
      c_side_in.light = s_p1[CB:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_sat_num_ff <= c_sat_num_in;
      c_sat_den_ff <= {den_sat, 1'b0};
      c_hue_num_ff <= c_hue_num_in;
      c_hue_den_ff <= {b_d_ff, 1'b0};
      c_side_ff    <= c_side_in;
   end

   // dividers
   logic             sat_vld, hue_vld;
   logic [QUO_W-1:0] sat_quo, hue_quo;

   rhc_div #(
      .NUM_W (SAT_NUM_W),
      .DEN_W (SAT_DEN_W),
      .QUO_W (QUO_W)
   ) u_sat_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_vld_ff),
      .in_num    (c_sat_num_ff),
      .in_den    (c_sat_den_ff),
      .out_valid (sat_vld),
      .out_quo   (sat_quo)
   );

   rhc_div #(
      .NUM_W (HUE_NUM_W),
      .DEN_W (HUE_DEN_W),
      .QUO_W (QUO_W)
   ) u_hue_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_vld_ff),
      .in_num    (c_hue_num_ff),
      .in_den    (c_hue_den_ff),
      .out_valid (hue_vld),
      .out_quo   (hue_quo)
   );

   // side data travels alongside the divider stages
   side_type side_ff [0:QUO_W-1];
   side_type side_out;

   always_ff @(posedge clock) begin
      side_ff[0] <= c_side_ff;
      for (int i = 1; i < QUO_W; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   assign side_out = side_ff[QUO_W-1];

   // hue offset, wrap and output register
   logic [HUE_MAG_W-1:0] mag;
   logic [HUE_W:0]       wrap_sum;
   logic [HUE_W-1:0]     rsp_hue_in;
   logic [CB-1:0]        rsp_sat_in;

   logic                 rsp_valid_ff;
   logic [HUE_W-1:0]     rsp_hue_ff;
   logic [CB-1:0]        rsp_sat_ff;
   logic [CB-1:0]        rsp_light_ff;

   always_comb begin
      mag = hue_quo[HUE_MAG_W-1:0];
      wrap_sum = (HUE_W+1)'(side_out.ofs) + (HUE_W+1)'(HUE_FULL) - (HUE_W+1)'(mag);
      if (wrap_sum >= (HUE_W+1)'(HUE_FULL)) begin
         wrap_sum = wrap_sum - (HUE_W+1)'(HUE_FULL);
      end
      if (side_out.gray) begin
         rsp_hue_in = '0;
         rsp_sat_in = '0;
      end else begin
         rsp_sat_in = sat_quo[CB-1:0];
         if (side_out.neg) begin
            rsp_hue_in = wrap_sum[HUE_W-1:0];
         end else begin
            rsp_hue_in = side_out.ofs + HUE_W'(mag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= hue_vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hue_ff   <= rsp_hue_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_light_ff <= side_out.light;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hue        = rsp_hue_ff;
   assign rsp_saturation = rsp_sat_ff;
   assign rsp_lightness  = rsp_light_ff;

   `CHK_ALWAYS(a_div_vld_match, clock, reset, sat_vld == hue_vld)
   `CHK_IMPLY(a_hue_mag_range, clock, reset, hue_vld && !side_out.gray, hue_quo <= QUO_W'(HUE_SIXTH))
   `CHK_IMPLY(a_sat_range, clock, reset, sat_vld && !side_out.gray, sat_quo <= QUO_W'(CH_MAX))
   `CHK_IMPLY(a_hue_out_range, clock, reset, rsp_valid_ff, rsp_hue_ff < HUE_W'(HUE_FULL))

endmodule

// File: sim/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CH_W = 8;
   localparam int CH_MAX = (1 << CH_W) - 1;
   localparam int HUE_W = rhc_pkg::HUE_W;
   localparam int PIPE_DEPTH = 13;
   localparam int N_RANDOM = 400;
   localparam int N_DIRECTED = 23;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [CH_W-1:0]  sat;
      logic [CH_W-1:0]  light;
   } hsl_type;

   typedef struct {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      bit              known;
      hsl_type         hsl;
   } pixel_case_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [CH_W-1:0]           req_red;
   logic [CH_W-1:0]           req_green;
   logic [CH_W-1:0]           req_blue;
   logic                      rsp_valid;
   logic [HUE_W-1:0]          rsp_hue;
   logic [CH_W-1:0]           rsp_saturation;
   logic [CH_W-1:0]           rsp_lightness;

   hsl_type hsl_pending_q[$];
   int      mismatches = 0;
   int      burst_left = 0;

   pixel_case_type directed_cases [0:N_DIRECTED-1] = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, '{13'd0,    8'd0,   8'd0}},
      '{8'd255, 8'd255, 8'd255, 1'b1, '{13'd0,    8'd0,   8'd255}},
      '{8'd128, 8'd128, 8'd128, 1'b1, '{13'd0,    8'd0,   8'd128}},
      '{8'd255, 8'd0,   8'd0,   1'b1, '{13'd0,    8'd255, 8'd128}},
      '{8'd0,   8'd255, 8'd0,   1'b1, '{13'd1920, 8'd255, 8'd128}},
      '{8'd0,   8'd0,   8'd255, 1'b1, '{13'd3840, 8'd255, 8'd128}},
      '{8'd255, 8'd255, 8'd0,   1'b1, '{13'd960,  8'd255, 8'd128}},
      '{8'd0,   8'd255, 8'd255, 1'b1, '{13'd2880, 8'd255, 8'd128}},
      '{8'd255, 8'd0,   8'd255, 1'b1, '{13'd4800, 8'd255, 8'd128}},
      '{8'd1,   8'd0,   8'd0,   1'b0, '{13'd0,    8'd0,   8'd0}},
      '{8'd0,   8'd0,   8'd1,   1'b0, '{13'd0,    8'd0,   8'd0}},
      '{8'd255, 8'd0,   8'd1,   1'b0, '{13'd0,    8'd0,   8'd0}},
      '{8'd254, 8'd255, 8'd255, 1'b0, '{13'd0,    8'd0,   8'd0}},
      '{8'd200, 8'd55,  8'd55,  1'b0, '{13'd0,    8'd0,   8'd0}},
      '{8'd200, 8'd54,  8'd54,  1'b0, '{13'd0,    8'd0,   8'd0}},
      '{8'd128, 8'd1,   8'd0,   1'b0, '{13'd0,    8'd0,   8'd0}},
      '{8'd128, 8'd0,   8'd1,   1'b0, '{13'd0,    8'd0,   8'd0}},
      '{8'd255, 8'd254, 8'd254, 1'b0, '{13'd0,    8'd0,   8'd0}},
      '{8'd85,  8'd170, 8'd255, 1'b0, '{13'd0,    8'd0,   8'd0}},
      '{8'd170, 8'd85,  8'd0,   1'b0, '{13'd0,    8'd0,   8'd0}},
      '{8'd1,   8'd1,   8'd0,   1'b0, '{13'd0,    8'd0,   8'd0}},
      '{8'd0,   8'd1,   8'd1,   1'b0, '{13'd0,    8'd0,   8'd0}},
      '{8'd3,   8'd2,   8'd1,   1'b0, '{13'd0,    8'd0,   8'd0}}
   };

   rgb_to_hsl_convert_unit #(
      .CHANNEL_BITS(CH_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .rsp_valid(rsp_valid),
      .rsp_hue(rsp_hue),
      .rsp_saturation(rsp_saturation),
      .rsp_lightness(rsp_lightness)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic int round_div(input int num, input int den);
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic hsl_type predict_hsl(input logic [CH_W-1:0] red,
                                           input logic [CH_W-1:0] green,
                                           input logic [CH_W-1:0] blue);
      int r, g, b, hi, lo, span, total, pos, neg, ofs, mag, hue;
      hsl_type res;
      r = int'(red);
      g = int'(green);
      b = int'(blue);
      hi = (r > g) ? r : g;
      hi = (b > hi) ? b : hi;
      lo = (r < g) ? r : g;
      lo = (b < lo) ? b : lo;
      span = hi - lo;
      total = hi + lo;
      res.light = CH_W'((total + 1) >> 1);
      res.hue = '0;
      res.sat = '0;
      if (span != 0) begin
         if (total < CH_MAX) res.sat = CH_W'(round_div(CH_MAX * span, total));
         else res.sat = CH_W'(round_div(CH_MAX * span, 2 * CH_MAX - total));
         if (hi == r) begin
            pos = g; neg = b; ofs = 0;
         end else if (hi == g) begin
            pos = b; neg = r; ofs = rhc_pkg::HUE_GREEN_OFS;
         end else begin
            pos = r; neg = g; ofs = rhc_pkg::HUE_BLUE_OFS;
         end
         if (pos >= neg) begin
            mag = round_div(rhc_pkg::HUE_SIXTH * (pos - neg), span);
            hue = (ofs + mag) % rhc_pkg::HUE_FULL;
         end else begin
            mag = round_div(rhc_pkg::HUE_SIXTH * (neg - pos), span);
            hue = (ofs + rhc_pkg::HUE_FULL - mag) % rhc_pkg::HUE_FULL;
         end
         res.hue = HUE_W'(hue);
      end
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task automatic send_pixel(input logic [CH_W-1:0] red, input logic [CH_W-1:0] green,
                             input logic [CH_W-1:0] blue, input hsl_type want, input int gap);
      @(negedge clock);
      start <= 1'b1;
      req_red <= red;
      req_green <= green;
      req_blue <= blue;
      @(posedge clock);
      while (busy) @(posedge clock);
      hsl_pending_q.push_back(want);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         req_red <= CH_W'($urandom);
         req_green <= CH_W'($urandom);
         req_blue <= CH_W'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (hsl_pending_q.size() != 0) @(posedge clock);
   endtask

   function automatic int draw_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(15, 40);
      return $urandom_range(0, 19);
   endfunction

   always @(posedge clock) begin
      hsl_type want;
      if (!reset && rsp_valid) begin
         if (hsl_pending_q.size() == 0) begin
            report_mismatch($sformatf("result with no request pending: hue %0d sat %0d light %0d",
                                      rsp_hue, rsp_saturation, rsp_lightness));
         end else begin
            want = hsl_pending_q.pop_front();
            if (rsp_hue !== want.hue)
               report_mismatch($sformatf("hue got %0d want %0d", rsp_hue, want.hue));
            if (rsp_saturation !== want.sat)
               report_mismatch($sformatf("saturation got %0d want %0d",
                                         rsp_saturation, want.sat));
            if (rsp_lightness !== want.light)
               report_mismatch($sformatf("lightness got %0d want %0d",
                                         rsp_lightness, want.light));
         end
      end
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [CH_W-1:0] r, g, b;
      hsl_type want;
      reset = 1'b1;
      start = 1'b0;
      req_red = '0;
      req_green = '0;
      req_blue = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         r = directed_cases[i].red;
         g = directed_cases[i].green;
         b = directed_cases[i].blue;
         want = directed_cases[i].known ? directed_cases[i].hsl : predict_hsl(r, g, b);
         send_pixel(r, g, b, want, (i < 12) ? 0 : draw_gap());
      end
      drain_results();

      for (int i = 0; i < N_RANDOM; i++) begin
         r = CH_W'($urandom);
         g = CH_W'($urandom);
         b = CH_W'($urandom);
         case ($urandom_range(0, 9))
            0: begin
               g = r;
               b = r;
            end
            1: g = r;
            2: b = g;
            3: b = r;
            4: begin
               r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            5: begin
               g = CH_W'(r + $urandom_range(0, 2));
               b = CH_W'(r - $urandom_range(0, 2));
            end
            default: ;
         endcase
         send_pixel(r, g, b, predict_hsl(r, g, b), draw_gap());
         if (i == N_RANDOM / 2) drain_results();
      end

      @(negedge clock);
      start <= 1'b0;
      drain_results();
      repeat (PIPE_DEPTH + 8) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
